[sv/lfia_pkg.sv]
// lfia_pkg: shared types and constants for the lowest-free identifier allocator.
// Holds operation and status codes and the command and response beat structs.
// No dependencies.
`default_nettype none

package lfia_pkg;

  // Default slot count and reset value of the max_ids register.
  localparam int unsigned MAX_SLOTS_DEF = 64;
  localparam int unsigned MAX_IDS_W     = 7;
  localparam logic [MAX_IDS_W-1:0] MAX_IDS_RESET = 7'd64;

  // Fixed widths of the beat fields.
  localparam int unsigned ID_W = 6;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_MAIN    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_LOOKUP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_INVALID   = 2'd2,
    ST_NOT_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    op_t             operation;
    logic [ID_W-1:0] id_in;
  } cmd_t;

  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] id_out;
    logic            occupied;
  } rsp_t;

endpackage

`default_nettype wire

[sv/lfia_ffs.sv]
// lfia_ffs: find-first-set priority encoder, lowest index wins.
// Used by the allocator to locate the next free slot. No package dependency.
`default_nettype none

module lfia_ffs #(
  parameter int unsigned WIDTH = 64
) (
  input  wire logic [WIDTH-1:0]         vec,
  output logic      [$clog2(WIDTH)-1:0] idx,
  output logic                          found
);

  localparam int unsigned IW = $clog2(WIDTH);

  // Scan from the top so the lowest set bit is the last one written.
  always_comb begin
    idx   = '0;
    found = 1'b0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx   = IW'(i);
        found = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/lowest_free_id_allocator_unit.sv]
// lowest_free_id_allocator_unit: top level of the lowest-free identifier allocator.
// Depends on lfia_pkg (types, codes) and lfia_ffs (next-free search).
//
//   channel   direction  handshake                       payload
//   command   in         start, accepted when !busy      cmd  (lfia_pkg::cmd_t)
//   response  out        done, one-cycle strobe          rsp  (lfia_pkg::rsp_t)
//   config    in         cfg_we, taken on every edge     cfg_data (max_ids, 7 bits)
//
// Flow: a command beat is captured in the input register, worked on in the
// next cycle, and its response beat is then taken into the done and rsp registers.
// One command is taken every cycle outside reset; the next-free search is a
// single find-first-set over the occupancy bitmap, so state is ready in time.
// Reset: rst clears the bitmap, table length and lowest free id, loads
// max_ids with 64 and holds busy high. The receiver cannot stall: every
// response beat is shown for exactly one cycle.
`default_nettype none

module lowest_free_id_allocator_unit #(
  parameter int unsigned MAX_SLOTS = lfia_pkg::MAX_SLOTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire lfia_pkg::cmd_t                    cmd,
  output logic                                   done,
  output lfia_pkg::rsp_t                         rsp,
  input  wire logic                              cfg_we,
  input  wire logic [lfia_pkg::MAX_IDS_W-1:0]    cfg_data
);

  // Slot index, count (0..MAX_SLOTS) and compare widths.
  localparam int unsigned SW = $clog2(MAX_SLOTS);
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned LW = (CW > lfia_pkg::MAX_IDS_W) ? CW : lfia_pkg::MAX_IDS_W;

  // Architectural state.
  logic [MAX_SLOTS-1:0]           slot_in_use;
  logic [CW-1:0]                  table_length;
  logic [CW-1:0]                  lowest_free;
  logic [lfia_pkg::MAX_IDS_W-1:0] max_ids;

  // Input register.
  logic           pend;
  lfia_pkg::cmd_t pend_cmd;

  // Next values.
  logic [MAX_SLOTS-1:0] slot_in_use_next;
  logic [CW-1:0]        table_length_next;
  logic [CW-1:0]        lowest_free_next;
  lfia_pkg::rsp_t       rsp_next;

  // Working signals.
  logic [LW-1:0]        limit;
  logic [LW-1:0]        lf_w;
  logic [LW-1:0]        len_w;
  logic [LW-1:0]        id_w;
  logic [SW-1:0]        grant;
  logic [SW-1:0]        id_idx;
  logic                 id_used;
  logic                 alloc_ok;
  logic [MAX_SLOTS-1:0] cand;
  logic [MAX_SLOTS-1:0] len_mask;
  logic [SW-1:0]        ffs_idx;
  logic                 ffs_found;
  logic [CW-1:0]        search_lf;

  // Accept a command on any cycle outside reset.
  assign busy = rst;

  // Widen everything to one compare width.
  assign lf_w    = LW'(lowest_free);
  assign len_w   = LW'(table_length);
  assign id_w    = LW'(pend_cmd.id_in);
  assign limit   = (LW'(max_ids) < LW'(MAX_SLOTS)) ? LW'(max_ids) : LW'(MAX_SLOTS);
  assign grant   = lf_w[SW-1:0];
  assign id_idx  = id_w[SW-1:0];
  assign id_used = (id_w < len_w) && slot_in_use[id_idx];
  assign alloc_ok = lf_w < limit;

  // Free slots strictly above the grant and below the table length.
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      len_mask[i] = LW'(i) < len_w;
      cand[i]     = !slot_in_use[i] && (LW'(i) > lf_w) && len_mask[i];
    end
  end

  lfia_ffs #(
    .WIDTH (MAX_SLOTS)
  ) u_ffs (
    .vec   (cand),
    .idx   (ffs_idx),
    .found (ffs_found)
  );

  // No free slot inside the table: park lowest_free at the table end.
  assign search_lf = ffs_found ? CW'(ffs_idx) : table_length;

  // Execute the held command against the current state.
  always_comb begin
    slot_in_use_next  = slot_in_use;
    table_length_next = table_length;
    lowest_free_next  = lowest_free;
    rsp_next.status   = lfia_pkg::ST_OK;
    rsp_next.id_out   = '0;
    rsp_next.occupied = 1'b0;
    case (pend_cmd.operation)
      lfia_pkg::OP_ALLOC: begin
        if (!alloc_ok) begin
          rsp_next.status = lfia_pkg::ST_FULL;
        end else begin
          slot_in_use_next[grant] = 1'b1;
          rsp_next.id_out = lf_w[lfia_pkg::ID_W-1:0];
          if (lf_w >= len_w) begin
            // Grow the table by the granted slot.
            table_length_next = lowest_free + CW'(1);
            lowest_free_next  = lowest_free + CW'(1);
          end else begin
            lowest_free_next = search_lf;
          end
        end
      end
      lfia_pkg::OP_MAIN: begin
        if (table_length == '0) begin
          slot_in_use_next[0] = 1'b1;
          table_length_next   = CW'(1);
          lowest_free_next    = CW'(1);
        end else begin
          rsp_next.status = lfia_pkg::ST_NOT_EMPTY;
        end
      end
      lfia_pkg::OP_RELEASE: begin
        if (id_used) begin
          slot_in_use_next[id_idx] = 1'b0;
          // Shrink by one only when the last slot goes.
          if (id_w + LW'(1) == len_w) begin
            table_length_next = id_w[CW-1:0];
          end
          if (id_w < lf_w) begin
            lowest_free_next = id_w[CW-1:0];
          end
        end else begin
          rsp_next.status = lfia_pkg::ST_INVALID;
        end
      end
      lfia_pkg::OP_LOOKUP: begin
        if (id_used) begin
          rsp_next.occupied = 1'b1;
        end else begin
          rsp_next.status = lfia_pkg::ST_INVALID;
        end
      end
      default: begin
        rsp_next.status = lfia_pkg::ST_INVALID;
      end
    endcase
  end

  // Input register: capture the command beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= start;
    end
    pend_cmd <= cmd;
  end

  // State and done register: table advances on a held command, max_ids on cfg_we.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_in_use  <= '0;
      table_length <= '0;
      lowest_free  <= '0;
      max_ids      <= lfia_pkg::MAX_IDS_RESET;
      done         <= 1'b0;
    end else begin
      done <= pend;
      if (pend) begin
        slot_in_use  <= slot_in_use_next;
        table_length <= table_length_next;
        lowest_free  <= lowest_free_next;
      end
      if (cfg_we) begin
        max_ids <= cfg_data;
      end
    end
  end

  // Response payload needs no reset; done qualifies it.
  always_ff @(posedge clk) begin
    if (pend) begin
      rsp <= rsp_next;
    end
  end

  // Each response beat comes from a command held in the previous cycle.
  a_done_from_pend: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(pend))
    else $error("response beat without a held command");

  // The lowest free id never lies beyond the table.
  a_lf_in_table: assert property (@(posedge clk) disable iff (rst)
    lowest_free <= table_length)
    else $error("lowest_free beyond table_length");

  // No slot at or above the table length is marked in use.
  a_no_stale_bits: assert property (@(posedge clk) disable iff (rst)
    (slot_in_use & ~len_mask) == '0)
    else $error("occupied slot outside the table");

  // A granted slot is in use in the following cycle.
  a_grant_taken: assert property (@(posedge clk) disable iff (rst)
    (pend && pend_cmd.operation == lfia_pkg::OP_ALLOC && alloc_ok)
      |=> slot_in_use[$past(grant)])
    else $error("granted slot not marked in use");

  // A successful grant never hands out a slot already taken.
  a_grant_free: assert property (@(posedge clk) disable iff (rst)
    (pend && pend_cmd.operation == lfia_pkg::OP_ALLOC && alloc_ok)
      |-> !slot_in_use[grant])
    else $error("grant of an occupied slot");

endmodule

`default_nettype wire
